@@ hdl/crc_protected_message_framer_macros.svh @@
// assertion macros for the framer back end
// expects clk and arst_n in the scope of each use
`ifndef CRC_PROTECTED_MESSAGE_FRAMER_MACROS_SVH
`define CRC_PROTECTED_MESSAGE_FRAMER_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("framer assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("framer assertion failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/cpmf_pkg.sv @@
// types, constants and crc helpers for the crc protected message framer
// no dependencies
package cpmf_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int IDX_W = 5;

	localparam logic [7:0] HDR_SYNC0 = 8'hA5;
	localparam logic [7:0] HDR_SYNC1 = 8'h5A;
	localparam logic [7:0] HDR_VERSION = 8'h01;
	localparam logic [7:0] HDR_FLAGS = 8'h00;
	localparam logic [IDX_W-1:0] HDR_LEN = 5'd15;
	localparam logic [IDX_W-1:0] HDR_CRC_FIRST = 5'd2;
	localparam logic [IDX_W-1:0] HDR_CRC_LAST = 5'd12;
	localparam logic [IDX_W-1:0] TRL_LEN = 5'd4;

	localparam logic [15:0] CRC16_POLY = 16'h1021;
	localparam logic [15:0] CRC16_INIT = 16'hFFFF;
	localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC32_INIT = 32'hFFFFFFFF;

	typedef enum logic {
		OP_BEGIN = 1'b0,
		OP_PAYLOAD = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CMD_HEADER,
		CMD_PAYLOAD,
		CMD_STRAY
	} cmd_kind_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  frame_type;
		logic [15:0] ev_code;
		logic [31:0] seq_num;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       end_of_message;
		logic       status;
	} rsp_t;

	// one queued command for the back end
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  frame_type;
		logic [15:0] ev_code;
		logic [31:0] seq_num;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
		logic        trail;
		logic [31:0] trail_crc;
	} cmd_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ({1'b0, c[31:1]} ^ CRC32_POLY) : {1'b0, c[31:1]};
		end
		return c;
	endfunction

endpackage

@@ hdl/crc_protected_message_framer.sv @@
// A begin word on req opens a message and yields a 15-byte header (sync A5 5A, version,
// type, flags, event id, sequence, length, crc-16/ccitt), each payload word yields its
// byte, and the closing payload word (or a zero-length begin) adds the 4-byte inverted
// crc-32 trailer. The byte output register moves one word per cycle while rsp_ready
// holds, so a payload word gives 1 byte (5 when it closes the message) and a begin word
// 15 (19 at zero length). The front end updates the payload crc-32 in the cycle a word
// is taken and places a command in a QUEUE_DEPTH-entry queue; the command being walked
// out keeps its entry until its last byte, so while a header drains req takes
// QUEUE_DEPTH-1 more words and then stalls. Payload words stream at one per cycle while
// rsp_ready holds. A payload word with no open message gives one word with status set.
// depends on cpmf_pkg, cpmf_front, cpmf_queue, cpmf_back
module crc_protected_message_framer #(
	parameter int QUEUE_DEPTH = cpmf_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cpmf_pkg::req_t req,
	input  logic           req_valid,
	output logic           req_ready,
	output cpmf_pkg::rsp_t rsp,
	output logic           rsp_valid,
	input  logic           rsp_ready
);
	import cpmf_pkg::*;

	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;
	cmd_t back_cmd;
	logic back_valid;
	logic back_ready;

	cpmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	cpmf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_cmd    (back_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	cpmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule

@@ hdl/cpmf_front.sv @@
// front end: accepts words, tracks the open message and the payload crc-32
// depends on cpmf_pkg
module cpmf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  cpmf_pkg::req_t req,
	input  logic           req_valid,
	output logic           req_ready,
	output cpmf_pkg::cmd_t cmd,
	output logic           cmd_valid,
	input  logic           cmd_ready
);
	import cpmf_pkg::*;

	logic        open_q;
	logic [15:0] rem_q;
	logic [31:0] crc_q;
	logic        accept;
	logic [31:0] crc_next;
	logic [15:0] rem_next;

	assign req_ready = cmd_ready;
	assign cmd_valid = req_valid;
	assign accept = req_valid && cmd_ready;
	assign crc_next = crc32_byte(crc_q, req.data_byte);
	assign rem_next = rem_q - 16'd1;

	always_comb begin
		cmd.frame_type = req.frame_type;
		cmd.ev_code = req.ev_code;
		cmd.seq_num = req.seq_num;
		cmd.payload_length = req.payload_length;
		cmd.data_byte = req.data_byte;
		cmd.kind = CMD_STRAY;
		cmd.trail = 1'b0;
		cmd.trail_crc = ~CRC32_INIT;
		if (req.op == OP_BEGIN) begin
			cmd.kind = CMD_HEADER;
			cmd.trail = (req.payload_length == 16'd0);
		end else if (open_q) begin
			cmd.kind = CMD_PAYLOAD;
			cmd.trail = (rem_next == 16'd0);
			cmd.trail_crc = ~crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			rem_q <= '0;
			crc_q <= CRC32_INIT;
		end else if (accept) begin
			if (req.op == OP_BEGIN) begin
				// zero length leaves the message closed; the header carries the trailer
				open_q <= (req.payload_length != 16'd0);
				rem_q <= req.payload_length;
				crc_q <= CRC32_INIT;
			end else if (open_q) begin
				if (rem_next == 16'd0) begin
					open_q <= 1'b0;
					rem_q <= '0;
					crc_q <= CRC32_INIT;
				end else begin
					rem_q <= rem_next;
					crc_q <= crc_next;
				end
			end
		end
	end

endmodule

@@ hdl/cpmf_queue.sv @@
// small command queue between front and back end
// depends on cpmf_pkg
module cpmf_queue #(
	parameter int DEPTH = cpmf_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cpmf_pkg::cmd_t push_cmd,
	input  logic           push_valid,
	output logic           push_ready,
	output cpmf_pkg::cmd_t pop_cmd,
	output logic           pop_valid,
	input  logic           pop_ready
);
	import cpmf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_cmd = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ hdl/cpmf_back.sv @@
// back end: walks each queued command out as bytes, header crc-16 on the fly
// depends on cpmf_pkg and the framer assertion macros
`include "crc_protected_message_framer_macros.svh"
module cpmf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  cpmf_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	output cpmf_pkg::rsp_t rsp,
	output logic           rsp_valid,
	input  logic           rsp_ready
);
	import cpmf_pkg::*;

	localparam logic [IDX_W-1:0] HDR_END = HDR_LEN - 5'd1;
	localparam logic [IDX_W-1:0] HDR_TRL_END = HDR_LEN + TRL_LEN - 5'd1;

	logic [IDX_W-1:0] idx_q;
	logic [15:0]      hcrc_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             load;
	logic             emit;
	logic             done;
	logic             in_trailer;
	logic [IDX_W-1:0] toff;
	logic [7:0]       byte_d;
	logic             st_d;

	assign load = !rsp_valid_q || rsp_ready;
	assign emit = cmd_valid && load;
	assign cmd_ready = load && done;
	assign rsp = rsp_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		byte_d = 8'h00;
		done = 1'b0;
		st_d = 1'b0;
		in_trailer = 1'b0;
		toff = '0;
		unique case (cmd.kind)
			CMD_HEADER: begin
				if (idx_q >= HDR_LEN) begin
					in_trailer = 1'b1;
					toff = idx_q - HDR_LEN;
				end else begin
					case (idx_q)
						5'd0: byte_d = HDR_SYNC0;
						5'd1: byte_d = HDR_SYNC1;
						5'd2: byte_d = HDR_VERSION;
						5'd3: byte_d = cmd.frame_type;
						5'd4: byte_d = HDR_FLAGS;
						5'd5: byte_d = cmd.ev_code[7:0];
						5'd6: byte_d = cmd.ev_code[15:8];
						5'd7: byte_d = cmd.seq_num[7:0];
						5'd8: byte_d = cmd.seq_num[15:8];
						5'd9: byte_d = cmd.seq_num[23:16];
						5'd10: byte_d = cmd.seq_num[31:24];
						5'd11: byte_d = cmd.payload_length[7:0];
						5'd12: byte_d = cmd.payload_length[15:8];
						5'd13: byte_d = hcrc_q[7:0];
						default: byte_d = hcrc_q[15:8];
					endcase
				end
				done = ((idx_q == HDR_END) && !cmd.trail) || (idx_q == HDR_TRL_END);
			end
			CMD_PAYLOAD: begin
				if (idx_q != '0) begin
					in_trailer = 1'b1;
					toff = idx_q - 5'd1;
				end else begin
					byte_d = cmd.data_byte;
				end
				done = ((idx_q == '0) && !cmd.trail) || (idx_q == TRL_LEN);
			end
			CMD_STRAY: begin
				st_d = 1'b1;
				done = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
		if (in_trailer) begin
			byte_d = cmd.trail_crc[{toff[1:0], 3'b000} +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hcrc_q <= CRC16_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rsp_valid_q <= cmd_valid;
			end
			if (emit) begin
				if (done) begin
					idx_q <= '0;
					hcrc_q <= CRC16_INIT;
				end else begin
					idx_q <= idx_q + 5'd1;
					// version through length feed the header crc
					if (cmd.kind == CMD_HEADER && idx_q >= HDR_CRC_FIRST &&
						idx_q <= HDR_CRC_LAST) begin
						hcrc_q <= crc16_byte(hcrc_q, byte_d);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.out_byte <= byte_d;
			rsp_q.last_of_run <= done;
			rsp_q.end_of_message <= in_trailer && (toff[1:0] == 2'd3);
			rsp_q.status <= st_d;
		end
	end

	`ASSERT_IMPLIES(a_idx_range, 1'b1, idx_q <= HDR_TRL_END)
	`ASSERT_IMPLIES(a_eom_is_last, rsp_valid_q && rsp_q.end_of_message, rsp_q.last_of_run)
	`ASSERT_IMPLIES(a_stray_word, rsp_valid_q && rsp_q.status,
		rsp_q.last_of_run && !rsp_q.end_of_message && rsp_q.out_byte == 8'h00)
	`ASSERT_NEXT(a_idx_restart, emit && done, idx_q == '0 && hcrc_q == CRC16_INIT)

endmodule

@@ sim/crc_protected_message_framer_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for crc_protected_message_framer: directed table, a burst of
// begins behind a held output, then random framed traffic; depends on cpmf_pkg and the framer rtl
// predicts each output word from its own model of the framer unless a typed-in word replaces it
module crc_protected_message_framer_tb;
	import cpmf_pkg::*;

	localparam int CLK_PERIOD = 2;
	localparam int RANDOM_ITEMS = 430;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam rsp_t STRAY_WORD = '{out_byte: 8'h00, last_of_run: 1'b1, end_of_message: 1'b0,
		status: 1'b1};

	typedef struct {
		req_t word;
		bit   typed;
		rsp_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	req_t req;
	logic req_valid;
	logic req_ready;
	rsp_t rsp;
	logic rsp_valid;
	logic rsp_ready;

	// side band riding with req: a typed-in expectation replaces the prediction
	bit   req_is_typed;
	rsp_t req_typed_word;

	rsp_t expected_words[$];
	stim_row_t stim_table[$];
	int mismatches = 0;
	int items_sent = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit rx_hold = 1'b0;

	// framer state as predicted
	bit          msg_open;
	logic [15:0] left_bytes;
	logic [31:0] body_crc;

	crc_protected_message_framer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp(rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// bit-serial ccitt, msb first
	function automatic logic [15:0] ccitt_update(input logic [15:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) c = c ^ CRC16_POLY;
		end
		return c;
	endfunction

	// bit-serial reflected crc-32, lsb first
	function automatic logic [31:0] body_crc_update(input logic [31:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) c = c ^ CRC32_POLY;
		end
		return c;
	endfunction

	function automatic void push_word(input logic [7:0] b, input logic last, input logic eom,
			input logic st);
		expected_words.push_back('{out_byte: b, last_of_run: last, end_of_message: eom,
			status: st});
	endfunction

	function automatic void close_message();
		logic [31:0] trl;
		trl = ~body_crc;
		for (int i = 0; i < 4; i++)
			push_word(trl[8*i +: 8], i == 3, i == 3, 1'b0);
		msg_open = 1'b0;
		left_bytes = '0;
		body_crc = CRC32_INIT;
	endfunction

	function automatic void frame_item(input req_t w);
		logic [7:0] hdr [15];
		logic [15:0] hc;
		if (w.op == OP_BEGIN) begin
			hdr[0] = HDR_SYNC0;
			hdr[1] = HDR_SYNC1;
			hdr[2] = HDR_VERSION;
			hdr[3] = w.frame_type;
			hdr[4] = HDR_FLAGS;
			hdr[5] = w.ev_code[7:0];
			hdr[6] = w.ev_code[15:8];
			for (int i = 0; i < 4; i++)
				hdr[7 + i] = w.seq_num[8*i +: 8];
			hdr[11] = w.payload_length[7:0];
			hdr[12] = w.payload_length[15:8];
			hc = CRC16_INIT;
			for (int i = 2; i < 13; i++)
				hc = ccitt_update(hc, hdr[i]);
			hdr[13] = hc[7:0];
			hdr[14] = hc[15:8];
			// a begin while open just drops the old message
			msg_open = 1'b1;
			left_bytes = w.payload_length;
			body_crc = CRC32_INIT;
			for (int i = 0; i < 15; i++)
				push_word(hdr[i], (i == 14) && (w.payload_length != 0), 1'b0, 1'b0);
			if (w.payload_length == 0) close_message();
		end else if (!msg_open) begin
			expected_words.push_back(STRAY_WORD);
		end else begin
			body_crc = body_crc_update(body_crc, w.data_byte);
			left_bytes = left_bytes - 16'd1;
			push_word(w.data_byte, left_bytes != 0, 1'b0, 1'b0);
			if (left_bytes == 0) close_message();
		end
	endfunction

	function automatic req_t random_word(input op_t kind);
		req_t w;
		w.op = kind;
		w.frame_type = 8'($urandom);
		w.ev_code = 16'($urandom);
		w.seq_num = $urandom;
		w.payload_length = 16'($urandom);
		w.data_byte = 8'($urandom);
		return w;
	endfunction

	function automatic void add_row(input op_t op, input logic [7:0] mt, input logic [15:0] ev,
			input logic [31:0] sq, input logic [15:0] len, input logic [7:0] db,
			input bit typed, input rsp_t want);
		stim_row_t r;
		r.word = '{op: op, frame_type: mt, ev_code: ev, seq_num: sq, payload_length: len,
			data_byte: db};
		r.typed = typed;
		r.want = want;
		stim_table.push_back(r);
	endfunction

	task automatic send_word(input req_t w, input bit typed, input rsp_t want);
		int gap;
		if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= w;
		req_is_typed <= typed;
		req_typed_word <= want;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	task automatic drain_framer();
		req_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// scoreboard: both handshakes sampled at the same edge, input side first
	always @(posedge clk) begin : scoreboard
		int n0;
		rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				n0 = expected_words.size();
				frame_item(req);
				if (req_is_typed) begin
					while (expected_words.size() > n0) void'(expected_words.pop_back());
					expected_words.push_back(req_typed_word);
				end
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: out_byte %h last %b eom %b status %b",
						rsp.out_byte, rsp.last_of_run, rsp.end_of_message, rsp.status);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (rsp.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, got %h", want.out_byte, rsp.out_byte);
						mismatches++;
					end
					if (rsp.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %b, got %b", want.last_of_run,
							rsp.last_of_run);
						mismatches++;
					end
					if (rsp.end_of_message !== want.end_of_message) begin
						$error("end_of_message: expected %b, got %b", want.end_of_message,
							rsp.end_of_message);
						mismatches++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %b, got %b", want.status, rsp.status);
						mismatches++;
					end
				end
			end
		end
	end

	// output side back pressure
	initial begin : receiver
		int n;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold) begin
				rx_hold = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
			n = rx_burst ? 0 : $urandom_range(0, 11);
			if (n > 0) begin
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin : watchdog
		#2000000;
		$display("[crc_protected_message_framer] ERROR");
		$finish;
	end

	initial begin : stimulus
		int pick;
		int len;
		int n_bytes;
		int next_drain;
		req_t w;
		msg_open = 1'b0;
		left_bytes = '0;
		body_crc = CRC32_INIT;
		arst_n = 1'b0;
		req = '0;
		req_valid = 1'b0;
		req_is_typed = 1'b0;
		req_typed_word = '0;

		// stray words with every field at its extremes
		add_row(OP_PAYLOAD, 8'h00, 16'h0000, 32'h00000000, 16'h0000, 8'hFF, 1, STRAY_WORD);
		add_row(OP_PAYLOAD, 8'hFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 8'h00, 1, STRAY_WORD);
		// zero-length messages: header straight into trailer
		add_row(OP_BEGIN, 8'h00, 16'h0000, 32'h00000000, 16'h0000, 8'hFF, 0, '0);
		add_row(OP_BEGIN, 8'hFF, 16'hFFFF, 32'hFFFFFFFF, 16'h0000, 8'h00, 0, '0);
		add_row(OP_PAYLOAD, 8'h12, 16'h3456, 32'h789ABCDE, 16'h0003, 8'h5A, 1, STRAY_WORD);
		// normal messages of three bytes and of one byte
		add_row(OP_BEGIN, 8'h01, 16'h1234, 32'h89ABCDEF, 16'h0003, 8'h00, 0, '0);
		add_row(OP_PAYLOAD, 8'hFF, 16'hFFFF, 32'hFFFFFFFF, 16'h0000, 8'h00, 1,
			rsp_t'{8'h00, 1'b1, 1'b0, 1'b0});
		add_row(OP_PAYLOAD, 8'h00, 16'h0000, 32'h00000000, 16'hFFFF, 8'hFF, 1,
			rsp_t'{8'hFF, 1'b1, 1'b0, 1'b0});
		add_row(OP_PAYLOAD, 8'h00, 16'h0000, 32'h00000000, 16'h0000, 8'h5A, 0, '0);
		add_row(OP_BEGIN, 8'h02, 16'hABCD, 32'h01234567, 16'h0001, 8'h00, 0, '0);
		add_row(OP_PAYLOAD, 8'h00, 16'h0000, 32'h00000000, 16'h0000, 8'hA5, 0, '0);
		// begin while open abandons the message
		add_row(OP_BEGIN, 8'h03, 16'h0001, 32'h80000000, 16'h0004, 8'h00, 0, '0);
		add_row(OP_PAYLOAD, 8'h00, 16'h0000, 32'h00000000, 16'h0000, 8'h11, 1,
			rsp_t'{8'h11, 1'b1, 1'b0, 1'b0});
		add_row(OP_BEGIN, 8'h01, 16'hFFFF, 32'h00000001, 16'h0002, 8'h00, 0, '0);
		add_row(OP_PAYLOAD, 8'h00, 16'h0000, 32'h00000000, 16'h0000, 8'h22, 1,
			rsp_t'{8'h22, 1'b1, 1'b0, 1'b0});
		add_row(OP_PAYLOAD, 8'h00, 16'h0000, 32'h00000000, 16'h0000, 8'h33, 0, '0);
		// longest message, cut short by a zero-length begin
		add_row(OP_BEGIN, 8'h02, 16'h8000, 32'hDEADBEEF, 16'hFFFF, 8'h00, 0, '0);
		add_row(OP_PAYLOAD, 8'h00, 16'h0000, 32'h00000000, 16'h0000, 8'h7E, 1,
			rsp_t'{8'h7E, 1'b1, 1'b0, 1'b0});
		add_row(OP_PAYLOAD, 8'h00, 16'h0000, 32'h00000000, 16'h0000, 8'h81, 1,
			rsp_t'{8'h81, 1'b1, 1'b0, 1'b0});
		add_row(OP_BEGIN, 8'h03, 16'h0000, 32'h00000000, 16'h0000, 8'h00, 0, '0);
		add_row(OP_PAYLOAD, 8'h00, 16'h0000, 32'h00000000, 16'h0000, 8'hC3, 1, STRAY_WORD);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < stim_table.size(); i++)
			send_word(stim_table[i].word, stim_table[i].typed, stim_table[i].want);
		drain_framer();

		// stall the output while begins pile up behind it
		rx_hold = 1'b1;
		tx_burst = 1'b1;
		for (int i = 0; i < 6; i++) begin
			w = random_word(OP_BEGIN);
			w.payload_length = 16'($urandom_range(0, 2));
			send_word(w, 1'b0, '0);
		end
		tx_burst = 1'b0;
		drain_framer();

		next_drain = items_sent + 100;
		while (items_sent < stim_table.size() + 6 + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// noise: payload words between messages
				n_bytes = $urandom_range(1, 3);
				for (int i = 0; i < n_bytes; i++)
					send_word(random_word(OP_PAYLOAD), 1'b0, '0);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 10) len = 0;
				else if (pick < 80) len = $urandom_range(1, 8);
				else if (pick < 92) len = $urandom_range(9, 40);
				else len = $urandom_range(0, 65535);
				w = random_word(OP_BEGIN);
				w.payload_length = 16'(len);
				send_word(w, 1'b0, '0);
				// long messages and a few short ones are cut off by the next begin
				if (len > 40) n_bytes = $urandom_range(0, 5);
				else if ($urandom_range(0, 9) == 0) n_bytes = $urandom_range(0, len);
				else n_bytes = len;
				for (int i = 0; i < n_bytes; i++)
					send_word(random_word(OP_PAYLOAD), 1'b0, '0);
			end
			if (items_sent >= next_drain) begin
				drain_framer();
				next_drain = items_sent + 100;
			end
		end

		drain_framer();
		if (mismatches == 0) $display("[crc_protected_message_framer] OK");
		else $display("[crc_protected_message_framer] ERROR");
		$finish;
	end

endmodule
